// ===== design/dtt_pkg.sv =====
`default_nettype none

package dtt_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam int HANDLE_W   = 32;
    localparam int DEADLINE_W = 64;
    localparam int TAG_W      = 16;
    localparam int CONTEXT_W  = 32;

    // stream word widths
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 152;
    localparam int M_PAD_W   = 6;
    localparam int TUSER_W   = 2;

    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_CANCEL   = 2'd1,
        OP_EVENT    = 2'd2,
        OP_STATUS   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_SCHED_REPLY  = 2'd0,
        KIND_CANCEL_REPLY = 2'd1,
        KIND_FIRED        = 2'd2,
        KIND_EVENT_DONE   = 2'd3
    } kind_t;

    // one row of the slot memory
    typedef struct packed {
        logic [HANDLE_W-1:0]   handle;
        logic [DEADLINE_W-1:0] deadline;
        logic [TAG_W-1:0]      handler;
        logic [CONTEXT_W-1:0]  context_word;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

`default_nettype wire

// ===== design/dtt_ram.sv =====
`default_nettype none

module dtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/deadline_timer_slot_table.sv =====
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tuser: operation; tdata: time, handle, tag, context
// m_axis    out  tvalid/tready/tlast    tuser: kind; tdata: handle .. arm deadline
//
// Steps: an item is accepted, then one pass of the slot memory finds/cancels/fires,
// a turnaround restarts the read, one pass finds the earliest deadline, and the
// reply follows. Refused requests and status skip the first pass and the turnaround.
// Both passes are paced by the slot memory's single read port, one slot a cycle bar stalls.
// Reset: valid bits cleared at once, next handle = 1; the slot memory needs no clearing.
// Stalls: a fired word waiting on m_axis holds the scan at the next due slot;
// the final word sits in the output register while the next item is already accepted.
`default_nettype none

module deadline_timer_slot_table
    import dtt_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [63:0] time_value, [95:64] handle_in, [111:96] handler_tag, [143:112] context_in
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] operation
    input  wire logic [TUSER_W-1:0]   s_axis_tuser,

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [31:0] handle_out, [32] success, [48:33] handler_out, [80:49] context_out,
    // [81] armed, [145:82] arm_deadline, [151:146] zero
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // [1:0] kind
    output logic [TUSER_W-1:0]        m_axis_tuser,
    output logic                      m_axis_tlast
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    // one-hot sequencer
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,  // waiting for a word
        S_SCAN = 5'b00010,  // first pass: allocate / cancel / fire
        S_PREP = 5'b00100,  // restart read at slot 0
        S_MIN  = 5'b01000,  // second pass: earliest deadline
        S_DONE = 5'b10000   // final reply
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [HANDLE_W-1:0]  next_handle_reg, next_handle_next;

    // latched request
    op_t                   op_reg, op_next;
    logic [DEADLINE_W-1:0] tv_reg, tv_next;
    logic [HANDLE_W-1:0]   hin_reg, hin_next;
    logic [TAG_W-1:0]      tag_reg, tag_next;
    logic [CONTEXT_W-1:0]  ctx_reg, ctx_next;

    // per-item results
    logic [HANDLE_W-1:0]   hres_reg, hres_next;
    logic                  ok_reg, ok_next;
    logic [DEADLINE_W-1:0] min_reg, min_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    kind_t                 out_kind_reg, out_kind_next;
    logic [HANDLE_W-1:0]   out_handle_reg, out_handle_next;
    logic                  out_success_reg, out_success_next;
    logic [TAG_W-1:0]      out_handler_reg, out_handler_next;
    logic [CONTEXT_W-1:0]  out_context_reg, out_context_next;
    logic                  out_armed_reg, out_armed_next;
    logic [DEADLINE_W-1:0] out_deadline_reg, out_deadline_next;
    logic                  out_last_reg, out_last_next;

    logic                  accept;
    logic                  out_free;
    logic                  last_slot;
    logic [HANDLE_W-1:0]   alloc_handle;
    logic                  is_armed;
    op_t                   in_op;
    logic [TAG_W-1:0]      in_tag;
    logic [HANDLE_W-1:0]   in_hin;

    logic                  ram_wr_en;
    logic [ENTRY_W-1:0]    ram_wr_data;
    logic [ENTRY_W-1:0]    ram_rd_data;
    slot_entry_t           rd_entry;
    slot_entry_t           wr_entry;

    // rd_data always holds the row of idx_reg: the read address is idx_next
    dtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS),
        .ADDR_W(IDX_W)
    ) u_slot_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(idx_reg),
        .wr_data(ram_wr_data),
        .rd_addr(idx_next),
        .rd_data(ram_rd_data)
    );

    assign rd_entry    = slot_entry_t'(ram_rd_data);
    assign ram_wr_data = ENTRY_W'(wr_entry);

    assign wr_entry.handle       = alloc_handle;
    assign wr_entry.deadline     = tv_reg;
    assign wr_entry.handler      = tag_reg;
    assign wr_entry.context_word = ctx_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign last_slot     = (idx_reg == LAST_IDX);

    assign in_op  = op_t'(s_axis_tuser);
    assign in_hin = s_axis_tdata[95:64];
    assign in_tag = s_axis_tdata[111:96];

    // the counter skips zero
    assign alloc_handle = (next_handle_reg == '0) ? HANDLE_W'(1) : next_handle_reg;
    assign is_armed     = (min_reg != '1);

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        valid_next        = valid_reg;
        next_handle_next  = next_handle_reg;
        op_next           = op_reg;
        tv_next           = tv_reg;
        hin_next          = hin_reg;
        tag_next          = tag_reg;
        ctx_next          = ctx_reg;
        hres_next         = hres_reg;
        ok_next           = ok_reg;
        min_next          = min_reg;
        out_kind_next     = out_kind_reg;
        out_handle_next   = out_handle_reg;
        out_success_next  = out_success_reg;
        out_handler_next  = out_handler_reg;
        out_context_next  = out_context_reg;
        out_armed_next    = out_armed_reg;
        out_deadline_next = out_deadline_reg;
        out_last_next     = out_last_reg;
        out_valid_next    = out_valid_reg && !m_axis_tready;
        ram_wr_en         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    op_next   = in_op;
                    tv_next   = s_axis_tdata[63:0];
                    hin_next  = in_hin;
                    tag_next  = in_tag;
                    ctx_next  = s_axis_tdata[143:112];
                    hres_next = '0;
                    ok_next   = 1'b0;
                    min_next  = '1;
                    case (in_op)
                        OP_SCHEDULE: state_next = (in_tag != '0) ? S_SCAN : S_MIN;
                        OP_CANCEL:   state_next = (in_hin != '0) ? S_SCAN : S_MIN;
                        OP_EVENT:    state_next = S_SCAN;
                        default:     state_next = S_MIN;
                    endcase
                end
            end

            S_SCAN:
            begin
                case (op_reg)
                    OP_SCHEDULE:
                    begin
                        if (!valid_reg[idx_reg])
                        begin
                            ram_wr_en           = 1'b1;
                            valid_next[idx_reg] = 1'b1;
                            hres_next           = alloc_handle;
                            next_handle_next    = alloc_handle + HANDLE_W'(1);
                            state_next          = S_PREP;
                        end
                        else if (last_slot)
                        begin
                            state_next = S_PREP;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end

                    OP_CANCEL:
                    begin
                        if (valid_reg[idx_reg] && rd_entry.handle == hin_reg)
                        begin
                            valid_next[idx_reg] = 1'b0;
                            ok_next             = 1'b1;
                            state_next          = S_PREP;
                        end
                        else if (last_slot)
                        begin
                            state_next = S_PREP;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end

                    OP_EVENT:
                    begin
                        if (valid_reg[idx_reg] && rd_entry.deadline <= tv_reg)
                        begin
                            // due slot: hold here until the output register frees up
                            if (out_free)
                            begin
                                valid_next[idx_reg] = 1'b0;
                                out_valid_next      = 1'b1;
                                out_kind_next       = KIND_FIRED;
                                out_handle_next     = rd_entry.handle;
                                out_success_next    = 1'b0;
                                out_handler_next    = rd_entry.handler;
                                out_context_next    = rd_entry.context_word;
                                out_armed_next      = 1'b0;
                                out_deadline_next   = '0;
                                out_last_next       = 1'b0;
                                if (last_slot)
                                begin
                                    state_next = S_PREP;
                                end
                                else
                                begin
                                    idx_next = idx_reg + IDX_W'(1);
                                end
                            end
                        end
                        else if (last_slot)
                        begin
                            state_next = S_PREP;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end

                    default:
                    begin
                        state_next = S_PREP;
                    end
                endcase
            end

            S_PREP:
            begin
                idx_next   = '0;
                state_next = S_MIN;
            end

            S_MIN:
            begin
                if (valid_reg[idx_reg] && rd_entry.deadline < min_reg)
                begin
                    min_next = rd_entry.deadline;
                end
                if (last_slot)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_handler_next  = '0;
                    out_context_next  = '0;
                    out_armed_next    = is_armed;
                    out_deadline_next = is_armed ? min_reg : '0;
                    out_last_next     = 1'b1;
                    case (op_reg)
                        OP_SCHEDULE:
                        begin
                            out_kind_next    = KIND_SCHED_REPLY;
                            out_handle_next  = hres_reg;
                            out_success_next = (hres_reg != '0);
                        end
                        OP_CANCEL:
                        begin
                            out_kind_next    = KIND_CANCEL_REPLY;
                            out_handle_next  = '0;
                            out_success_next = ok_reg;
                        end
                        default:
                        begin
                            out_kind_next    = KIND_EVENT_DONE;
                            out_handle_next  = '0;
                            out_success_next = 1'b0;
                        end
                    endcase
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                idx_next   = '0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            valid_reg       <= '0;
            next_handle_reg <= HANDLE_W'(1);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            valid_reg       <= valid_next;
            next_handle_reg <= next_handle_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        tv_reg           <= tv_next;
        hin_reg          <= hin_next;
        tag_reg          <= tag_next;
        ctx_reg          <= ctx_next;
        hres_reg         <= hres_next;
        ok_reg           <= ok_next;
        min_reg          <= min_next;
        out_kind_reg     <= out_kind_next;
        out_handle_reg   <= out_handle_next;
        out_success_reg  <= out_success_next;
        out_handler_reg  <= out_handler_next;
        out_context_reg  <= out_context_next;
        out_armed_reg    <= out_armed_next;
        out_deadline_reg <= out_deadline_next;
        out_last_reg     <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_deadline_reg, out_armed_reg,
                            out_context_reg, out_handler_reg, out_success_reg,
                            out_handle_reg};

    // a fired timer is never the closing word of an item
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_FIRED |-> !m_axis_tlast)
    else $error("fired word marked last");

    // allocation only lands in a free slot
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> !valid_reg[idx_reg] && state_reg == S_SCAN)
    else $error("schedule overwrote a live slot");

    // a successful schedule reply never carries handle zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_SCHED_REPLY && m_axis_tdata[32]
        |-> m_axis_tdata[31:0] != '0)
    else $error("zero handle granted");

    // an accepted word always starts work
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg != S_IDLE)
    else $error("accepted word dropped");

endmodule

`default_nettype wire
